FILE: hdl/srcs_pkg.sv
// Shared types, codes and constants of the sparse row/column slicer.
package srcs_pkg;

   localparam int DEF_MAX_COLUMNS = 65536;
   localparam int EPOCH_WIDTH     = 8;
   localparam int INDEX_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int COL_WIDE_WIDTH  = 24;
   localparam int LIMIT_WIDTH     = 25;

   localparam logic [1:0] OP_MARK    = 2'd0;
   localparam logic [1:0] OP_EDGE    = 2'd1;
   localparam logic [1:0] OP_ROW_END = 2'd2;
   localparam logic [1:0] OP_START   = 2'd3;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_ROW_PTR = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HAS_VALUES   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMN_COUNT = 1'b1;

   localparam logic [16:0] COLUMN_COUNT_RESET = 17'h10000;
   localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;

   localparam logic [EPOCH_WIDTH-1:0] EPOCH_FIRST = EPOCH_WIDTH'(1);
   localparam logic [EPOCH_WIDTH-1:0] EPOCH_LAST  = {EPOCH_WIDTH{1'b1}};

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        column_id;
      logic [15:0]        new_index;
      logic [31:0]        edge_position;
      logic signed [63:0] edge_value;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [31:0]        slot;
      logic [15:0]        out_column;
      logic signed [63:0] out_payload;
   } rsp_type;

   typedef struct packed {
      logic mark;
      logic start;
   } map_ctrl_type;

   typedef struct packed {
      logic                   hit;
      logic [INDEX_WIDTH-1:0] new_index;
   } map_hit_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

FILE: hdl/srcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end

endmodule

FILE: hdl/srcs_colmap.sv
// Column map: epoch-tagged selection memory with its clearing sweep.
module srcs_colmap #(
   parameter int MAX_COLUMNS = srcs_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  srcs_pkg::map_ctrl_type               ctrl,
   input  logic [$clog2(MAX_COLUMNS)-1:0]       addr,
   input  logic [srcs_pkg::INDEX_WIDTH-1:0]     new_index,
   output srcs_pkg::map_hit_type                lookup,
   output logic                                 busy
);
   import srcs_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int MW = EPOCH_WIDTH + INDEX_WIDTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLUMNS - 1);

   logic [EPOCH_WIDTH-1:0] epoch_ff, epoch_in;
   logic                   clear_ff, clear_in;
   logic [AW-1:0]          clear_addr_ff, clear_addr_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [MW-1:0] ram_wdata;
   logic [MW-1:0] ram_rdata;

   srcs_ram #(
      .WIDTH(MW),
      .DEPTH(MAX_COLUMNS)
   ) u_ram (
      .clock       (clock),
      .write_enable(ram_we),
      .write_addr  (ram_waddr),
      .write_data  (ram_wdata),
      .read_addr   (addr),
      .read_data   (ram_rdata)
   );

   always_comb begin
      epoch_in      = epoch_ff;
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr;
      ram_wdata     = {epoch_ff, new_index};
      if (clear_ff) begin
         // sweep: stamp every entry with the never-current epoch zero
         ram_we        = 1'b1;
         ram_waddr     = clear_addr_ff;
         ram_wdata     = '0;
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end else if (ctrl.mark) begin
         ram_we = 1'b1;
      end else if (ctrl.start) begin
         if (epoch_ff == EPOCH_LAST) begin
            clear_in      = 1'b1;
            clear_addr_in = '0;
            epoch_in      = EPOCH_FIRST;
         end else begin
            epoch_in = epoch_ff + EPOCH_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= EPOCH_FIRST;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         epoch_ff      <= epoch_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // A tag equal to the live epoch means marked since the last start.
   assign lookup.hit       = (ram_rdata[MW-1:INDEX_WIDTH] == epoch_ff);
   assign lookup.new_index = ram_rdata[INDEX_WIDTH-1:0];
   assign busy             = clear_ff;

endmodule

FILE: hdl/sparse_row_column_slicer.sv
// Top level of the sparse row/column slicer: decode, counters and result register.
// Path: an accepted transaction waits in stage 1 for the map read, then its result is registered.
// Throughput: one transaction per cycle while busy is low; marks and dropped edges give no result.
// Reset (synchronous): counters and control flags clear, then the column map memory is swept
// over all MAX_COLUMNS entries with busy high. Every 255th start wraps the map's epoch tag and
// launches the same sweep right away; its row pointer result strobes during the sweep.
// Results cannot be stalled: each one is valid for exactly one cycle.
module sparse_row_column_slicer #(
   parameter int MAX_COLUMNS = srcs_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  srcs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output srcs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [srcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [srcs_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import srcs_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam logic [LIMIT_WIDTH-1:0] COLUMN_LIMIT = LIMIT_WIDTH'(MAX_COLUMNS);

   // configuration registers
   logic        has_values_ff;
   logic [16:0] column_count_ff;

   // stage 1: transaction waiting on the map read
   logic               s1_valid_ff;
   logic [1:0]         s1_op_ff;
   logic               s1_keep_ff;
   logic signed [63:0] s1_payload_ff;

   logic [31:0] edges_kept_ff, edges_kept_in;
   logic [31:0] rows_done_ff, rows_done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic [COL_WIDE_WIDTH-1:0]  col_wide;
   logic                       in_range;
   logic                       below_count;
   logic [AW-1:0]              map_addr;
   map_ctrl_type               map_ctrl;
   map_hit_type                map_hit;
   logic                       map_busy;

   assign accept      = start && !map_busy;
   assign col_wide    = {{(COL_WIDE_WIDTH - 16){1'b0}}, req_data.column_id};
   assign in_range    = ({1'b0, col_wide} < COLUMN_LIMIT);
   assign below_count = ({1'b0, req_data.column_id} < column_count_ff);
   assign map_addr    = col_wide[AW-1:0];

   // Marks outside the map are ignored; edges read the map regardless and drop later.
   assign map_ctrl.mark   = accept && (req_data.operation == OP_MARK) && in_range;
   assign map_ctrl.start  = accept && (req_data.operation == OP_START);

   srcs_colmap #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_colmap (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (map_ctrl),
      .addr     (map_addr),
      .new_index(req_data.new_index),
      .lookup   (map_hit),
      .busy     (map_busy)
   );

   // Configuration: user writes only while idle (not enforced); no ordering vs transactions.
   always_ff @(posedge clock) begin
      if (reset) begin
         has_values_ff   <= 1'b0;
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HAS_VALUES:   has_values_ff   <= csr_write_data[0];
            CSR_COLUMN_COUNT: column_count_ff <= csr_write_data;
            default:          ;
         endcase
      end
   end

   // Capture the transaction; pick the edge payload now so stage 1 only muxes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_op_ff      <= req_data.operation;
      s1_keep_ff    <= in_range && below_count;
      s1_payload_ff <= has_values_ff ? req_data.edge_value
                                     : $signed({32'd0, req_data.edge_position});
   end

   // Stage 1: map data is back; update counters and build the result.
   always_comb begin
      edges_kept_in = edges_kept_ff;
      rows_done_in  = rows_done_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      if (s1_valid_ff) begin
         case (s1_op_ff)
            OP_EDGE: begin
               if (s1_keep_ff && map_hit.hit) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result_kind = KIND_EDGE;
                  rsp_data_in.slot        = edges_kept_ff;
                  rsp_data_in.out_column  = map_hit.new_index;
                  rsp_data_in.out_payload = s1_payload_ff;
                  edges_kept_in           = sat_inc(edges_kept_ff);
               end
            end
            OP_ROW_END: begin
               // counters hold at all ones once saturated
               rows_done_in            = sat_inc(rows_done_ff);
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = KIND_ROW_PTR;
               rsp_data_in.slot        = rows_done_in;
               rsp_data_in.out_payload = $signed({32'd0, edges_kept_ff});
            end
            OP_START: begin
               edges_kept_in           = '0;
               rows_done_in            = '0;
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = KIND_ROW_PTR;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_kept_ff <= '0;
         rows_done_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         edges_kept_ff <= edges_kept_in;
         rows_done_ff  <= rows_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = map_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // nothing enters stage 1 behind a busy cycle
   a_no_issue_while_busy: assert property (@(posedge clock) disable iff (reset)
      $past(map_busy) |-> !s1_valid_ff)
      else $error("transaction issued while the map sweep was running");

   // a start always answers with row pointer entry zero
   a_start_ptr_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == OP_START)) |=>
         (rsp_valid_ff && (rsp_data_ff.result_kind == KIND_ROW_PTR) &&
          (rsp_data_ff.slot == 32'd0) && (rsp_data_ff.out_payload == 64'sd0)))
      else $error("start did not produce row pointer zero");

   // a kept edge advances the slot counter unless it is saturated
   a_kept_edge_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && (rsp_data_in.result_kind == KIND_EDGE)) |=>
         ((edges_kept_ff == $past(edges_kept_ff) + 32'd1) ||
          (edges_kept_ff == COUNT_MAX)))
      else $error("kept edge did not advance the edge counter");

endmodule
